FILE: sv/assert_macros.svh
// assertion macros shared by the tone generator rtl
// expects a clock named clk and a synchronous active-high reset named rst in scope
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked outside reset
`define ASSERT_IMPLIES(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, checked outside reset
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

FILE: sv/est_pkg.sv
// shared types and constants for the enveloped sine tone generator
// no dependencies; imported by every module of the block
`timescale 1ns / 1ps
`default_nettype none

package est_pkg;

  // parameter defaults
  localparam int SAMPLE_RATE_DEF    = 44100;
  localparam int PHASE_BITS_DEF     = 32;
  localparam int SINE_ROM_DEPTH_DEF = 256;

  // field and datapath widths
  localparam int FREQ_W    = 15;
  localparam int DUR_W     = 16;
  localparam int VOL_W     = 7;
  localparam int LEN_W     = 16;
  localparam int COUNT_W   = 22;
  localparam int ENV_W     = 16;
  localparam int AMP_W     = 15;
  localparam int MAG_W     = 15;
  localparam int SAMPLE_W  = 16;
  localparam int DIVISOR_W = 17;   // holds the largest sample rate

  localparam logic [COUNT_W-1:0]   COUNT_MAX = '1;
  localparam logic [DIVISOR_W-1:0] MS_PER_S  = DIVISOR_W'(1000);
  localparam logic [VOL_W-1:0]     VOL_MAX   = VOL_W'(100);
  localparam logic [ENV_W-1:0]     ENV_FULL  = '1;

  typedef enum logic [1:0] {
    OP_START = 2'd0,
    OP_TICK  = 2'd1,
    OP_STOP  = 2'd2
  } op_t;

  typedef enum logic [1:0] {
    REG_VOLUME  = 2'd0,
    REG_ATTACK  = 2'd1,
    REG_RELEASE = 2'd2
  } reg_idx_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

`default_nettype wire

FILE: sv/est_divider.sv
// shared restoring divider, one quotient bit per cycle
// depends on est_pkg for the status struct
`timescale 1ns / 1ps
`default_nettype none

module est_divider
  import est_pkg::*;
#(
  parameter int DIVIDEND_W = 48,
  parameter int DIVISR_W   = DIVISOR_W
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  start,
  input  wire logic [DIVIDEND_W-1:0] dividend,
  input  wire logic [DIVISR_W-1:0]   divisor,
  output logic      [DIVIDEND_W-1:0] quotient,
  output div_stat_t                  stat
);

  localparam int CNT_W = $clog2(DIVIDEND_W + 1);

  logic [DIVISR_W-1:0]   rem;
  logic [DIVISR_W-1:0]   dvs;
  logic [DIVIDEND_W-1:0] quo;
  logic [CNT_W-1:0]      cnt;
  logic                  busy;
  logic                  done;
  logic [DIVISR_W:0]     trial;
  logic                  take;

  assign trial = {rem, quo[DIVIDEND_W-1]};
  assign take  = trial >= {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
        rem  <= '0;
        quo  <= dividend;
        dvs  <= divisor;
      end else if (busy) begin
        rem <= take ? DIVISR_W'(trial - {1'b0, dvs}) : trial[DIVISR_W-1:0];
        quo <= {quo[DIVIDEND_W-2:0], take};
        cnt <= cnt + 1'b1;
        if (cnt == CNT_W'(DIVIDEND_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign quotient  = quo;
  assign stat.busy = busy;
  assign stat.done = done;

endmodule

`default_nettype wire

FILE: sv/est_sine.sv
// quarter-wave sine lookup from the phase accumulator, two registered stages
// depends on est_pkg for widths; the table is built at elaboration
`timescale 1ns / 1ps
`default_nettype none

module est_sine
  import est_pkg::*;
#(
  parameter int PHASE_BITS     = PHASE_BITS_DEF,
  parameter int SINE_ROM_DEPTH = SINE_ROM_DEPTH_DEF
) (
  input  wire logic                  clk,
  input  wire logic [PHASE_BITS-1:0] phase,
  output logic      [MAG_W-1:0]      mag,
  output logic                       neg
);

  localparam int IDX_W  = $clog2(4 * SINE_ROM_DEPTH);
  localparam int ADDR_W = $clog2(SINE_ROM_DEPTH);
  localparam int PROD_W = PHASE_BITS + IDX_W;
  localparam logic [63:0] PI_HALF_Q30 = 64'd1686629713;
  localparam logic [63:0] ONE_Q30     = 64'd1073741824;
  localparam logic [IDX_W-1:0] Q1_START = IDX_W'(SINE_ROM_DEPTH);
  localparam logic [IDX_W-1:0] Q2_START = IDX_W'(2 * SINE_ROM_DEPTH);
  localparam logic [IDX_W-1:0] Q3_START = IDX_W'(3 * SINE_ROM_DEPTH);

  // taylor series in q2.30, rounded to q1.15
  function automatic logic [15:0] quarter_sine(input int unsigned i);
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] term;
    logic [63:0] sum;
    x    = (PI_HALF_Q30 * 64'(i)) / SINE_ROM_DEPTH;
    x2   = (x * x) >> 30;
    term = x;
    sum  = x;
    term = ((term * x2) >> 30) / 6;
    sum  = sum - term;
    term = ((term * x2) >> 30) / 20;
    sum  = sum + term;
    term = ((term * x2) >> 30) / 42;
    sum  = sum - term;
    term = ((term * x2) >> 30) / 72;
    sum  = sum + term;
    term = ((term * x2) >> 30) / 110;
    sum  = sum - term;
    term = ((term * x2) >> 30) / 156;
    sum  = sum + term;
    if (sum > ONE_Q30) sum = ONE_Q30;
    quarter_sine = 16'((sum * 64'd32767 + (ONE_Q30 >> 1)) >> 30);
  endfunction

  logic [15:0] rom [SINE_ROM_DEPTH];

  for (genvar g = 0; g < SINE_ROM_DEPTH; g++) begin : g_rom
    assign rom[g] = quarter_sine(g);
  end

  logic [PROD_W-1:0] idx_prod;
  logic [IDX_W-1:0]  idx;
  logic [1:0]        quarter;
  logic [IDX_W-1:0]  base;
  logic [ADDR_W-1:0] pos;
  logic [ADDR_W-1:0] addr;
  logic              at_peak;

  assign idx_prod = PROD_W'(phase) * PROD_W'(4 * SINE_ROM_DEPTH);

  // stage 1: table index from the phase
  always_ff @(posedge clk) begin
    idx <= idx_prod[PROD_W-1:PHASE_BITS];
  end

  // quarter by compares, position within it
  always_comb begin
    if (idx >= Q3_START) begin
      quarter = 2'd3;
      base    = Q3_START;
    end else if (idx >= Q2_START) begin
      quarter = 2'd2;
      base    = Q2_START;
    end else if (idx >= Q1_START) begin
      quarter = 2'd1;
      base    = Q1_START;
    end else begin
      quarter = 2'd0;
      base    = '0;
    end
  end

  assign pos     = ADDR_W'(idx - base);
  assign at_peak = quarter[0] && (pos == '0);
  assign addr    = quarter[0] ? ADDR_W'(SINE_ROM_DEPTH - int'(pos)) : pos;

  // stage 2: registered table read, falling quarter peaks at full scale
  always_ff @(posedge clk) begin
    mag <= at_peak ? MAG_W'(32767) : rom[addr][MAG_W-1:0];
    neg <= quarter[1];
  end

endmodule

`default_nettype wire

FILE: sv/enveloped_sine_tone_generator.sv
// enveloped sine tone generator: note sequencer, envelope and output stage
// depends on est_pkg, est_divider, est_sine and assert_macros.svh
//
// channel   dir  handshake           payload
// s_*       in   s_tvalid/s_tready   s_tuser = op, s_tdata = tone_freq, note_ms
// m_*       out  m_tvalid/m_tready   m_tdata = sample, m_tlast = last_of_note
// apb       in   psel/penable        paddr 0 volume, 4 attack_length, 8 release_length
//
// a start transfer runs the shared divider twice (note length over 1000, then the
// phase increment), DIV_W = 47 by default; a tick on the flat part passes S_ENV,
// S_MUL1, S_MUL2 and S_OUT, in a rest S_ENV and S_OUT, in attack or release also
// S_ENV_WAIT, where the divider forms the envelope; stop and unused ops stay in
// S_IDLE; s_tready is high only when the sequencer is idle; a finished sample waits
// in S_OUT while the output register is full; synchronous reset, constant sine table
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module enveloped_sine_tone_generator
  import est_pkg::*;
#(
  parameter int SAMPLE_RATE    = SAMPLE_RATE_DEF,
  parameter int PHASE_BITS     = PHASE_BITS_DEF,
  parameter int SINE_ROM_DEPTH = SINE_ROM_DEPTH_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  // input stream
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [31:0] s_tdata,   // [14:0] tone_freq, [30:15] note_ms, [31] zero
  input  wire logic [1:0]  s_tuser,   // [1:0] op
  // output stream
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [15:0]      m_tdata,   // [15:0] sample
  output logic             m_tlast,
  // configuration
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  // dividend has to hold frequency << PHASE_BITS and remaining << 16
  localparam int ENV_DIVIDEND_W = COUNT_W + ENV_W;
  localparam int DIV_W    = (FREQ_W + PHASE_BITS > ENV_DIVIDEND_W) ?
                            FREQ_W + PHASE_BITS : ENV_DIVIDEND_W;
  localparam int DPROD_W  = DUR_W + DIVISOR_W;
  localparam int AENV_W   = AMP_W + ENV_W;
  localparam int MPROD_W  = AENV_W + MAG_W;
  localparam int SHIFT    = 31;

  typedef enum logic [8:0] {
    S_IDLE     = 9'b000000001,
    S_DUR_DIV  = 9'b000000010,
    S_DUR_WAIT = 9'b000000100,
    S_INC_WAIT = 9'b000001000,
    S_ENV      = 9'b000010000,
    S_ENV_WAIT = 9'b000100000,
    S_MUL1     = 9'b001000000,
    S_MUL2     = 9'b010000000,
    S_OUT      = 9'b100000000
  } state_t;

  state_t state;

  // configuration registers
  logic [VOL_W-1:0] volume;
  logic [LEN_W-1:0] attack_length;
  logic [LEN_W-1:0] release_length;

  // note state
  logic                  note_active;
  logic [PHASE_BITS-1:0] phase_acc;
  logic [PHASE_BITS-1:0] phase_increment;
  logic [COUNT_W-1:0]    sample_index;
  logic [COUNT_W-1:0]    note_samples;
  logic [LEN_W-1:0]      release_in_use;
  logic                  rest_flag;

  // per-transfer working registers
  logic [DPROD_W-1:0]  dur_prod;
  logic [FREQ_W-1:0]   freq_q;
  logic [COUNT_W-1:0]  remain_q;
  logic                last_q;
  logic [AMP_W-1:0]    amp;
  logic [ENV_W-1:0]    env;
  logic [AENV_W-1:0]   amp_env;
  logic [MPROD_W-1:0]  mag_prod;
  logic                neg_q;

  // input fields
  op_t                in_op;
  logic [FREQ_W-1:0]  in_freq;
  logic [DUR_W-1:0]   in_dur;
  logic               s_accept;

  assign in_op    = op_t'(s_tuser[1:0]);
  assign in_freq  = s_tdata[FREQ_W-1:0];
  assign in_dur   = s_tdata[FREQ_W +: DUR_W];
  assign s_tready = (state == S_IDLE) && !rst;
  assign s_accept = s_tvalid && s_tready;

  // ---------------------------------------------------------------------------
  // configuration port, writes land on the access phase
  // ---------------------------------------------------------------------------
  logic apb_write;

  assign pready    = 1'b1;
  assign apb_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      volume         <= VOL_MAX;
      attack_length  <= LEN_W'(220);
      release_length <= LEN_W'(1323);
    end else if (apb_write) begin
      unique case (reg_idx_t'(paddr[3:2]))
        REG_VOLUME:  volume         <= pwdata[VOL_W-1:0];
        REG_ATTACK:  attack_length  <= pwdata[LEN_W-1:0];
        REG_RELEASE: release_length <= pwdata[LEN_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx_t'(paddr[3:2]))
      REG_VOLUME:  prdata = 32'(volume);
      REG_ATTACK:  prdata = 32'(attack_length);
      REG_RELEASE: prdata = 32'(release_length);
      default:     prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // shared divider and its operand select
  // ---------------------------------------------------------------------------
  logic                 div_start;
  logic [DIV_W-1:0]     div_dividend;
  logic [DIVISOR_W-1:0] div_divisor;
  logic [DIV_W-1:0]     div_quotient;
  div_stat_t            div_stat;

  // envelope segment tests; release wins over attack
  logic rel_hit;
  logic atk_hit;

  assign rel_hit = remain_q < COUNT_W'(release_in_use);
  assign atk_hit = sample_index < COUNT_W'(attack_length);

  always_comb begin
    div_start    = 1'b0;
    div_dividend = DIV_W'(dur_prod);
    div_divisor  = MS_PER_S;
    unique case (state)
      S_DUR_DIV: begin
        div_start = 1'b1;
      end
      S_DUR_WAIT: begin
        // phase increment pass follows the length pass directly
        div_start    = div_stat.done;
        div_dividend = DIV_W'(freq_q) << PHASE_BITS;
        div_divisor  = DIVISOR_W'(SAMPLE_RATE);
      end
      S_ENV: begin
        div_start = !rest_flag && (rel_hit || atk_hit);
        if (rel_hit) begin
          div_dividend = DIV_W'({remain_q, ENV_W'(0)});
          div_divisor  = DIVISOR_W'(release_in_use);
        end else begin
          div_dividend = DIV_W'({sample_index, ENV_W'(0)});
          div_divisor  = DIVISOR_W'(attack_length);
        end
      end
      default: ;
    endcase
  end

  est_divider #(
    .DIVIDEND_W (DIV_W),
    .DIVISR_W   (DIVISOR_W)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .quotient (div_quotient),
    .stat     (div_stat)
  );

  // ---------------------------------------------------------------------------
  // sine lookup of phase_acc through the registered index and table-read stages
  // ---------------------------------------------------------------------------
  logic [MAG_W-1:0] sine_mag;
  logic             sine_neg;

  est_sine #(
    .PHASE_BITS     (PHASE_BITS),
    .SINE_ROM_DEPTH (SINE_ROM_DEPTH)
  ) u_sine (
    .clk   (clk),
    .phase (phase_acc),
    .mag   (sine_mag),
    .neg   (sine_neg)
  );

  // ---------------------------------------------------------------------------
  // note setup helpers
  // ---------------------------------------------------------------------------
  logic [COUNT_W-1:0] samples_sat;
  logic [COUNT_W-1:0] samples_half;
  logic [LEN_W-1:0]   release_clip;

  // note length saturates at the counter limit
  assign samples_sat  = (div_quotient > DIV_W'(COUNT_MAX)) ? COUNT_MAX
                                                           : div_quotient[COUNT_W-1:0];
  assign samples_half = samples_sat >> 1;
  // release never longer than half the note
  assign release_clip = (COUNT_W'(release_length) > samples_half) ?
                        samples_half[LEN_W-1:0] : release_length;

  // amplitude = 3 * v * v, volume above 100 treated as 100
  logic [VOL_W-1:0]   vol_clamped;
  logic [2*VOL_W-1:0] vol_sq;

  assign vol_clamped = (volume > VOL_MAX) ? VOL_MAX : volume;
  assign vol_sq      = vol_clamped * vol_clamped;

  // ---------------------------------------------------------------------------
  // result formation and output register
  // ---------------------------------------------------------------------------
  logic [MAG_W-1:0]    mag;
  logic [SAMPLE_W-1:0] sample_val;
  logic                out_load;

  assign mag = mag_prod[SHIFT +: MAG_W];

  always_comb begin
    if (rest_flag) begin
      sample_val = '0;
    end else if (neg_q) begin
      sample_val = -{1'b0, mag};
    end else begin
      sample_val = {1'b0, mag};
    end
  end

  assign out_load = (state == S_OUT) && (!m_tvalid || m_tready);

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_tdata <= sample_val;
      m_tlast <= last_q;
    end
  end

  // ---------------------------------------------------------------------------
  // sequencer
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= S_IDLE;
      m_tvalid        <= 1'b0;
      note_active     <= 1'b0;
      phase_acc       <= '0;
      phase_increment <= '0;
      sample_index    <= '0;
      note_samples    <= '0;
      release_in_use  <= '0;
      rest_flag       <= 1'b0;
    end else begin
      if (out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (s_accept) begin
            unique case (in_op)
              OP_START: begin
                // a new note replaces any note in progress
                dur_prod     <= DPROD_W'(in_dur) * DPROD_W'(SAMPLE_RATE);
                freq_q       <= in_freq;
                phase_acc    <= '0;
                sample_index <= '0;
                rest_flag    <= (in_freq == '0);
                note_active  <= 1'b0;
                state        <= S_DUR_DIV;
              end
              OP_TICK: begin
                if (note_active) begin
                  remain_q <= note_samples - sample_index;
                  last_q   <= ({1'b0, sample_index} + 1'b1) >= {1'b0, note_samples};
                  state    <= S_ENV;
                end
              end
              OP_STOP: begin
                note_active <= 1'b0;
              end
              default: ;
            endcase
          end
        end
        S_DUR_DIV: begin
          state <= S_DUR_WAIT;
        end
        S_DUR_WAIT: begin
          if (div_stat.done) begin
            note_samples   <= samples_sat;
            release_in_use <= release_clip;
            state          <= S_INC_WAIT;
          end
        end
        S_INC_WAIT: begin
          if (div_stat.done) begin
            phase_increment <= div_quotient[PHASE_BITS-1:0];
            note_active     <= (note_samples != '0);
            state           <= S_IDLE;
          end
        end
        S_ENV: begin
          amp <= AMP_W'({vol_sq, 1'b0}) + AMP_W'(vol_sq);
          env <= ENV_FULL;
          if (rest_flag) begin
            state <= S_OUT;
          end else if (div_start) begin
            state <= S_ENV_WAIT;
          end else begin
            state <= S_MUL1;
          end
        end
        S_ENV_WAIT: begin
          if (div_stat.done) begin
            env   <= div_quotient[ENV_W-1:0];
            state <= S_MUL1;
          end
        end
        S_MUL1: begin
          amp_env <= AENV_W'(amp) * AENV_W'(env);
          state   <= S_MUL2;
        end
        S_MUL2: begin
          mag_prod <= MPROD_W'(amp_env) * MPROD_W'(sine_mag);
          neg_q    <= sine_neg;
          state    <= S_OUT;
        end
        S_OUT: begin
          if (out_load) begin
            if (!rest_flag) begin
              phase_acc <= phase_acc + phase_increment;
            end
            sample_index <= sample_index + 1'b1;
            if (last_q) begin
              note_active <= 1'b0;
            end
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // assertions
  // ---------------------------------------------------------------------------
  logic div_waiting;

  assign div_waiting = (state == S_DUR_WAIT) || (state == S_INC_WAIT) || (state == S_ENV_WAIT);

  `ASSERT_IMPLIES(active_index_a, note_active, sample_index < note_samples, "index past note end")
  `ASSERT_IMPLIES(rel_clip_a, 1'b1, COUNT_W'(release_in_use) <= note_samples >> 1, "release too long")
  `ASSERT_NEXT(last_ends_note_a, out_load && last_q, !note_active, "note active after last")
  `ASSERT_IMPLIES(div_done_wait_a, div_stat.done, div_waiting, "divider result with no consumer")

endmodule

`default_nettype wire

FILE: dv/tb.sv
// testbench for the enveloped sine tone generator: stream stimulus, apb setup, sample checks
// depends on est_pkg and the enveloped_sine_tone_generator rtl; predicts every sample itself
`timescale 1ns / 1ps

module tb
  import est_pkg::*;
();

  localparam logic [1:0] OP_UNUSED    = 2'd3;   // op code the block must ignore
  localparam int         AMP_PER_VOL2 = 3;      // 30000 * (v/100)^2 == 3 * v * v
  localparam int         STALL_LIMIT  = 5000;   // cycles without any transfer
  localparam int         DRAIN_CYCLES = 300;    // covers a start (two divider passes) plus margin
  localparam int         HOLD_CYCLES  = 600;    // one long output back-pressure stretch
  localparam int         PHASE_ITEMS  = 60;

  typedef struct {
    logic [1:0]  op;
    logic [14:0] freq;
    logic [15:0] dur;
  } note_cmd_t;

  typedef struct {
    logic [15:0] sample;
    logic        last;
  } tone_sample_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [31:0] s_tdata = '0;    // [14:0] tone_freq, [30:15] note_ms, [31] zero
  logic [1:0]  s_tuser = '0;    // [1:0] op
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [15:0] m_tdata;         // [15:0] sample
  logic        m_tlast;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [3:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  enveloped_sine_tone_generator u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // pending commands for the driver and samples still owed by the block
  note_cmd_t    tone_cmds[$];
  tone_sample_t expected_samples[$];
  int           err_count = 0;
  int           res_count = 0;

  // register shadows, reset values
  int unsigned cfg_volume  = 100;
  int unsigned cfg_attack  = 220;
  int unsigned cfg_release = 1323;

  // tone predictor state
  bit          tone_on   = 1'b0;
  bit          is_rest   = 1'b0;
  logic [31:0] ph_acc    = '0;
  logic [31:0] ph_step   = '0;
  int unsigned smp_idx   = 0;
  int unsigned note_len  = 0;
  int unsigned rel_use   = 0;
  logic [15:0] quarter_rom [SINE_ROM_DEPTH_DEF];

  task automatic flag_error(input string msg);
    err_count++;
    $display("ERROR at %0t: %s", $time, msg);
  endtask

  // round(32767 * sin(pi/2 * i / depth)), taylor series in q2.30
  function automatic logic [15:0] quarter_wave(input int unsigned i);
    logic [63:0] x, x2, term, sum;
    int unsigned k;
    x = (64'd1686629713 * i) / SINE_ROM_DEPTH_DEF;
    x2 = (x * x) >> 30;
    term = x;
    sum = x;
    for (k = 1; k <= 6; k++) begin
      term = ((term * x2) >> 30) / 64'((2 * k) * (2 * k + 1));
      if (k[0]) sum = sum - term;
      else sum = sum + term;
    end
    if (sum > 64'd1073741824) sum = 64'd1073741824;
    return 16'((sum * 32767 + 64'd536870912) >> 30);
  endfunction

  // q1.15 sine of the top ten phase bits, built from the quarter wave
  function automatic int sine_at(input logic [31:0] phase);
    logic [9:0] idx;
    int mag;
    idx = phase[31:22];
    if (idx[8]) mag = (idx[7:0] == 0) ? 32767 : int'(quarter_rom[SINE_ROM_DEPTH_DEF - idx[7:0]]);
    else mag = int'(quarter_rom[idx[7:0]]);
    return idx[9] ? -mag : mag;
  endfunction

  // applies one accepted command to the tone state, queues the sample it yields
  task automatic advance_tone(input note_cmd_t cmd);
    longint unsigned total, env, mag, amp;
    int unsigned     vol, remaining, s_mag;
    int              s, value;
    bit              last;
    tone_sample_t    smp;
    if (cmd.op == OP_START) begin
      total = (64'(cmd.dur) * SAMPLE_RATE_DEF) / MS_PER_S;
      if (total > COUNT_MAX) total = COUNT_MAX;
      note_len = int'(total);
      rel_use = (cfg_release > note_len / 2) ? note_len / 2 : cfg_release;
      ph_step = 32'((64'(cmd.freq) << 32) / SAMPLE_RATE_DEF);
      ph_acc = '0;
      smp_idx = 0;
      is_rest = (cmd.freq == 0);
      tone_on = (note_len != 0);
    end else if (cmd.op == OP_STOP) begin
      tone_on = 1'b0;
    end else if (cmd.op == OP_TICK && tone_on) begin
      last = (smp_idx + 1 >= note_len);
      value = 0;
      if (!is_rest) begin
        vol = (cfg_volume > VOL_MAX) ? VOL_MAX : cfg_volume;
        amp = 64'(AMP_PER_VOL2 * vol * vol);
        env = 64'(ENV_FULL);
        remaining = note_len - smp_idx;
        s = sine_at(ph_acc);
        s_mag = (s < 0) ? -s : s;
        // release wins over attack when both apply
        if (smp_idx < cfg_attack) env = (64'(smp_idx) << 16) / cfg_attack;
        if (remaining < rel_use) env = (64'(remaining) << 16) / rel_use;
        mag = (amp * env * 64'(s_mag)) >> 31;
        value = (s < 0) ? -int'(mag) : int'(mag);
        ph_acc = ph_acc + ph_step;
      end
      smp.sample = value[15:0];
      smp.last = last;
      expected_samples.push_back(smp);
      smp_idx = (smp_idx + 1) & COUNT_MAX;
      if (last) tone_on = 1'b0;
    end
  endtask

  task automatic push_cmd(input logic [1:0] op, input logic [14:0] freq, input logic [15:0] dur);
    note_cmd_t c;
    c.op = op;
    c.freq = freq;
    c.dur = dur;
    tone_cmds.push_back(c);
  endtask

  // command with random payload fields
  task automatic push_noise(input logic [1:0] op);
    push_cmd(op, 15'($urandom_range(0, 32767)), 16'($urandom_range(0, 65535)));
  endtask

  // apb write, then a read back of the same register
  task automatic cfg_write(input reg_idx_t idx, input logic [31:0] val);
    logic [31:0] want;
    want = (idx == REG_VOLUME) ? (val & 32'h7F) : (val & 32'hFFFF);
    @(posedge clk);
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    // write lands on this edge; go straight into the read setup
    case (idx)
      REG_VOLUME: cfg_volume = want;
      REG_ATTACK: cfg_attack = want;
      default:    cfg_release = want;
    endcase
    pwrite <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    @(negedge clk);
    if (prdata !== want)
      flag_error($sformatf("reg %s read back %0h, wrote %0h", idx.name(), prdata, want));
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  // input driver: bursts of random length, random gaps, predicts on every transfer
  note_cmd_t on_bus;
  int        burst_left = 0;
  int        gap_left   = 0;

  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) advance_tone(on_bus);
      if (!s_tvalid || s_tready) begin
        if (gap_left > 0) begin
          gap_left--;
          s_tvalid <= 1'b0;
        end else if (tone_cmds.size() > 0) begin
          on_bus = tone_cmds.pop_front();
          s_tuser <= on_bus.op;
          s_tdata <= {1'b0, on_bus.dur, on_bus.freq};
          s_tvalid <= 1'b1;
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            // about a third of the bursts run straight into the next
            burst_left = $urandom_range(1, 40);
            gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 15);
          end
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // output stall pattern: always ready, coin flip, or one in four; plus one long hold-off
  int rx_mode   = 0;
  int mode_left = 0;
  int rx_tick   = 0;
  int hold_left = 0;
  bit held_once = 1'b0;

  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      m_tready <= 1'b0;
    end else if (!held_once && res_count >= 30) begin
      // the sender keeps offering ticks, so the block backs up to its input
      held_once = 1'b1;
      hold_left = HOLD_CYCLES;
      m_tready <= 1'b0;
    end else begin
      if (mode_left == 0) begin
        rx_mode = $urandom_range(0, 2);
        mode_left = $urandom_range(8, 64);
      end
      mode_left--;
      rx_tick++;
      case (rx_mode)
        0:       m_tready <= 1'b1;
        1:       m_tready <= 1'($urandom_range(0, 1));
        default: m_tready <= (rx_tick % 4 == 0);
      endcase
    end
  end

  // output monitor: every sample transfer against the oldest prediction
  always @(posedge clk) begin : sample_check
    tone_sample_t want;
    if (!rst && m_tvalid && m_tready) begin
      res_count <= res_count + 1;
      if (expected_samples.size() == 0) begin
        flag_error($sformatf("unexpected sample %0d last %0b", $signed(m_tdata), m_tlast));
      end else begin
        want = expected_samples.pop_front();
        if (m_tdata !== want.sample)
          flag_error($sformatf("sample %0d, predicted %0d", $signed(m_tdata),
                               $signed(want.sample)));
        if (m_tlast !== want.last)
          flag_error($sformatf("last_of_note %0b, predicted %0b", m_tlast, want.last));
      end
    end
  end

  // watchdog: ends the run when nothing moves on any port for too long
  int idle_cycles = 0;

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("FAILURE");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // register settings per phase; phase 0 keeps the reset values, phase 4 is random
  int unsigned vol_set[6] = '{100, 0, 127, 100, 0, 55};
  int unsigned att_set[6] = '{220, 0, 65535, 10, 0, 1};
  int unsigned rel_set[6] = '{1323, 0, 65535, 20, 0, 1};

  initial begin
    int unsigned i, ph, r, nsmp, nticks, phase_items;
    logic [14:0] f;
    logic [15:0] d;
    for (i = 0; i < SINE_ROM_DEPTH_DEF; i++) quarter_rom[i] = quarter_wave(i);
    vol_set[4] = $urandom_range(0, 127);
    att_set[4] = $urandom_range(0, 60);
    rel_set[4] = $urandom_range(0, 60);
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    for (ph = 0; ph < 6; ph++) begin
      if (ph > 0) begin
        cfg_write(REG_VOLUME, vol_set[ph]);
        cfg_write(REG_ATTACK, att_set[ph]);
        cfg_write(REG_RELEASE, rel_set[ph]);
      end

      if (ph == 0) begin
        // directed: short note, stop, idle ticks and stops, unused op, rest,
        // restart mid-note with all-ones fields, zero-length note
        push_cmd(OP_START, 15'd440, 16'd1);
        repeat (3) push_cmd(OP_TICK, 15'd0, 16'd0);
        push_cmd(OP_STOP, 15'd0, 16'd0);
        push_cmd(OP_TICK, 15'h7FFF, 16'hFFFF);
        push_cmd(OP_STOP, 15'h7FFF, 16'hFFFF);
        push_cmd(OP_UNUSED, 15'h7FFF, 16'hFFFF);
        push_cmd(OP_START, 15'd0, 16'd1);
        repeat (2) push_cmd(OP_TICK, 15'd0, 16'd0);
        push_cmd(OP_START, 15'h7FFF, 16'hFFFF);
        repeat (2) push_cmd(OP_TICK, 15'd0, 16'd0);
        push_cmd(OP_START, 15'd22050, 16'd0);
        push_cmd(OP_TICK, 15'd0, 16'd0);
        push_cmd(OP_START, 15'd22050, 16'hFFFF);
        push_cmd(OP_TICK, 15'd0, 16'd0);
        push_cmd(OP_STOP, 15'd0, 16'd0);
      end

      // random notes: mostly short ones ticked to the end, some cut short
      phase_items = 0;
      while (phase_items < PHASE_ITEMS) begin
        if ($urandom_range(0, 4) == 0) begin
          repeat ($urandom_range(1, 3)) begin
            case ($urandom_range(0, 2))
              0:       push_noise(OP_UNUSED);
              1:       push_noise(OP_STOP);
              default: push_noise(OP_TICK);
            endcase
          end
        end
        r = $urandom_range(0, 9);
        f = (r == 0) ? 15'd0 : (r == 1) ? 15'($urandom_range(0, 32767))
                                        : 15'($urandom_range(20, 8000));
        r = $urandom_range(0, 19);
        d = (r == 0) ? 16'd0 : (r == 1) ? 16'($urandom_range(0, 65535))
                                        : 16'($urandom_range(1, 2));
        push_cmd(OP_START, f, d);
        nsmp = d * SAMPLE_RATE_DEF / 1000;
        r = $urandom_range(0, 9);
        if (nsmp > 200) nticks = $urandom_range(1, 12);
        else if (r < 7) nticks = nsmp + $urandom_range(0, 3);
        else nticks = $urandom_range(0, nsmp);
        repeat (nticks) push_noise(OP_TICK);
        // a stop ends some cut notes, the rest get replaced by the next start
        if (r == 7 || nsmp > 200) push_cmd(OP_STOP, 15'd0, 16'd0);
        phase_items += nticks + 2;
      end

      // drain: all commands taken, all samples in, then room for a trailing start
      while (tone_cmds.size() != 0 || s_tvalid || expected_samples.size() != 0)
        @(posedge clk);
      repeat (DRAIN_CYCLES) @(posedge clk);
    end

    if (err_count == 0 && expected_samples.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

FILE: files.f
+incdir+sv
sv/est_pkg.sv
sv/est_divider.sv
sv/est_sine.sv
sv/enveloped_sine_tone_generator.sv
dv/tb.sv
